/* rtl/core/tlr_pkg.sv */
// Shared constants, command and register codes, and types of the thick line rasterizer.
package tlr_pkg;

   // Coordinate and brush sizes
   localparam int COORD_W    = 12;
   localparam int MAX_RADIUS = 15;
   localparam int RADIUS_W   = 4;
   localparam int BRUSH_W    = $clog2(2 * MAX_RADIUS + 2);
   localparam int ERR_W      = COORD_W + 3;

   // Configuration and payload widths
   localparam int COLOR_W    = 24;
   localparam int STRIDE_W   = 15;
   localparam int PBYTES_W   = 3;
   localparam int OFFSET_W   = 26;
   localparam int ROW_PROD_W = COORD_W + STRIDE_W;
   localparam int COL_PROD_W = COORD_W + PBYTES_W;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Reset values of the registers
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = '0;
   localparam logic [COLOR_W-1:0]  COLOR_RESET  = 24'hFFFF00;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 15'd768;
   localparam logic [PBYTES_W-1:0] PBYTES_RESET = 3'd3;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_BRUSH_RADIUS = 2'd0,
      REG_PEN_COLOR    = 2'd1,
      REG_ROW_STRIDE   = 2'd2,
      REG_PIXEL_BYTES  = 2'd3
   } reg_index_type;

   // One brush pixel on its way to the offset stage
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } pixel_type;

endpackage

/* rtl/core/thick_line_rasterizer_unit.sv */
// Top level of the thick line rasterizer: registers, walker, offset stage and result register.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   command, x_start, y_start, x_end, y_end
//  rsp      out        rsp_valid/rsp_stall   pixel_x, pixel_y, byte_offset, pixel_color,
//                                            last_pixel
//  csr      in/out     psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// One item is accepted per clock while req_stall is low; a step item's pixel is registered
// after the walker stage and again after the offset multiply stage. Load items and steps while
// idle yield nothing. Reset clears the walk and both valid flags and restores the
// register defaults. req_stall rises only while both the offset stage and the result
// register are full and rsp_stall holds the result.
module thick_line_rasterizer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [tlr_pkg::COORD_W-1:0]    req_x_start,
   input  logic [tlr_pkg::COORD_W-1:0]    req_y_start,
   input  logic [tlr_pkg::COORD_W-1:0]    req_x_end,
   input  logic [tlr_pkg::COORD_W-1:0]    req_y_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tlr_pkg::COORD_W-1:0]    rsp_pixel_x,
   output logic [tlr_pkg::COORD_W-1:0]    rsp_pixel_y,
   output logic [tlr_pkg::OFFSET_W-1:0]   rsp_byte_offset,
   output logic [tlr_pkg::COLOR_W-1:0]    rsp_pixel_color,
   output logic                           rsp_last_pixel,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tlr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tlr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tlr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import tlr_pkg::*;

   // Configuration registers
   logic [RADIUS_W-1:0]  radius_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic [STRIDE_W-1:0]  stride_ff;
   logic [PBYTES_W-1:0]  pbytes_ff;
   logic                 csr_write;
   reg_index_type        csr_index;

   // Pipeline
   logic                 accept;
   logic                 emit;
   pixel_type            walk_pixel;
   logic                 s1_open;
   logic                 out_open;
   logic                 s1_valid_ff, s1_valid_in;
   pixel_type            s1_pixel_ff;
   logic [OFFSET_W-1:0]  row_term;
   logic [OFFSET_W-1:0]  col_term;
   logic                 rsp_valid_ff;
   logic [COORD_W-1:0]   rsp_x_ff;
   logic [COORD_W-1:0]   rsp_y_ff;
   logic [OFFSET_W-1:0]  rsp_offset_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic                 rsp_last_ff;

   // Register access decode
   always_comb begin
      pready    = 1'b1;
      csr_index = reg_index_type'(paddr[3:2]);
      csr_write = psel && penable && pwrite;
   end

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         color_ff  <= COLOR_RESET;
         stride_ff <= STRIDE_RESET;
         pbytes_ff <= PBYTES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_BRUSH_RADIUS: radius_ff <= pwdata[RADIUS_W-1:0];
            REG_PEN_COLOR:    color_ff  <= pwdata[COLOR_W-1:0];
            REG_ROW_STRIDE:   stride_ff <= pwdata[STRIDE_W-1:0];
            REG_PIXEL_BYTES:  pbytes_ff <= pwdata[PBYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back registers
   always_comb begin
      case (csr_index)
         REG_BRUSH_RADIUS: prdata = CSR_DATA_W'(radius_ff);
         REG_PEN_COLOR:    prdata = CSR_DATA_W'(color_ff);
         REG_ROW_STRIDE:   prdata = CSR_DATA_W'(stride_ff);
         REG_PIXEL_BYTES:  prdata = CSR_DATA_W'(pbytes_ff);
         default:          prdata = '0;
      endcase
   end

   // Flow control: a stage opens when it is empty or its item moves on
   always_comb begin
      out_open    = !rsp_valid_ff || !rsp_stall;
      s1_open     = !s1_valid_ff || out_open;
      req_stall   = !s1_open;
      accept      = req_valid && s1_open;
      s1_valid_in = accept ? emit : (out_open ? 1'b0 : s1_valid_ff);
   end

   tlr_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .command      (req_command),
      .x_start      (req_x_start),
      .y_start      (req_y_start),
      .x_end        (req_x_end),
      .y_end        (req_y_end),
      .brush_radius (radius_ff),
      .emit         (emit),
      .pixel        (walk_pixel)
   );

   // Hold the walker's pixel for the offset stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= walk_pixel;
      end
   end

   // Frame byte offset, wrapped to the offset width
   always_comb begin
      row_term = OFFSET_W'(ROW_PROD_W'(s1_pixel_ff.y) * ROW_PROD_W'(stride_ff));
      col_term = OFFSET_W'(COL_PROD_W'(s1_pixel_ff.x) * COL_PROD_W'(pbytes_ff));
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open && s1_valid_ff) begin
         rsp_x_ff      <= s1_pixel_ff.x;
         rsp_y_ff      <= s1_pixel_ff.y;
         rsp_offset_ff <= row_term + col_term;
         rsp_color_ff  <= color_ff;
         rsp_last_ff   <= s1_pixel_ff.last;
      end
   end

   // Drive the result channel
   always_comb begin
      rsp_valid       = rsp_valid_ff;
      rsp_pixel_x     = rsp_x_ff;
      rsp_pixel_y     = rsp_y_ff;
      rsp_byte_offset = rsp_offset_ff;
      rsp_pixel_color = rsp_color_ff;
      rsp_last_pixel  = rsp_last_ff;
   end

endmodule

/* rtl/core/tlr_walker.sv */
// Line walk and brush scan: one brush pixel per accepted step item while a line is loaded.
module tlr_walker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         command,
   input  logic [tlr_pkg::COORD_W-1:0]  x_start,
   input  logic [tlr_pkg::COORD_W-1:0]  y_start,
   input  logic [tlr_pkg::COORD_W-1:0]  x_end,
   input  logic [tlr_pkg::COORD_W-1:0]  y_end,
   input  logic [tlr_pkg::RADIUS_W-1:0] brush_radius,
   output logic                         emit,
   output tlr_pkg::pixel_type           pixel
);
   import tlr_pkg::*;

   // Walk state; the brush center always sits on the walk point
   logic                      busy_ff, busy_in;
   logic [COORD_W-1:0]        walk_x_ff, walk_x_in;
   logic [COORD_W-1:0]        walk_y_ff, walk_y_in;
   logic [COORD_W-1:0]        stop_x_ff, stop_x_in;
   logic [COORD_W-1:0]        stop_y_ff, stop_y_in;
   logic                      neg_ff, neg_in;
   logic                      steep_ff, steep_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [COORD_W-1:0]        major_ff, major_in;
   logic [COORD_W-1:0]        minor_ff, minor_in;
   logic [BRUSH_W-1:0]        col_ff, col_in;
   logic [BRUSH_W-1:0]        row_ff, row_in;
   logic                      phase_ff, phase_in;

   logic [BRUSH_W-1:0]        radius_sat;
   logic [BRUSH_W-1:0]        span;
   logic                      at_end;
   logic                      brush_done;
   logic [COORD_W-1:0]        x_moved;
   logic signed [ERR_W-1:0]   err_up;
   logic signed [ERR_W-1:0]   err_down;
   logic                      err_le_zero;

   // Load setup terms
   logic                      ld_swap;
   logic [COORD_W-1:0]        ld_x1, ld_y1, ld_x2, ld_y2;
   logic                      ld_neg;
   logic [COORD_W-1:0]        ld_dx, ld_dy;
   logic                      ld_steep;
   logic [COORD_W-1:0]        ld_major, ld_minor;

   // Brush geometry and end tests
   always_comb begin
      radius_sat  = (32'(brush_radius) > 32'(MAX_RADIUS)) ? BRUSH_W'(MAX_RADIUS)
                                                          : BRUSH_W'(brush_radius);
      span        = BRUSH_W'({radius_sat, 1'b0});
      at_end      = steep_ff ? (walk_y_ff == stop_y_ff) : (walk_x_ff == stop_x_ff);
      brush_done  = (col_ff >= span) && (row_ff >= span);
      x_moved     = neg_ff ? (walk_x_ff - COORD_W'(1)) : (walk_x_ff + COORD_W'(1));
      err_up      = err_ff + ERR_W'({minor_ff, 1'b0});
      err_down    = err_ff + ERR_W'({minor_ff, 1'b0}) - ERR_W'({major_ff, 1'b0});
      err_le_zero = err_ff[ERR_W-1] || (err_ff == '0);
   end

   // Pixel under the brush for this step
   always_comb begin
      emit       = accept && (command == CMD_STEP) && busy_ff;
      pixel.x    = COORD_W'(walk_x_ff + COORD_W'(col_ff) - COORD_W'(radius_sat));
      pixel.y    = COORD_W'(walk_y_ff + COORD_W'(row_ff) - COORD_W'(radius_sat));
      pixel.last = brush_done && !phase_ff && at_end;
   end

   // Order endpoints so y rises and set up the Bresenham terms
   always_comb begin
      ld_swap  = y_start > y_end;
      ld_x1    = ld_swap ? x_end   : x_start;
      ld_y1    = ld_swap ? y_end   : y_start;
      ld_x2    = ld_swap ? x_start : x_end;
      ld_y2    = ld_swap ? y_start : y_end;
      ld_neg   = ld_x1 > ld_x2;
      ld_dx    = ld_neg ? (ld_x1 - ld_x2) : (ld_x2 - ld_x1);
      ld_dy    = ld_y2 - ld_y1;
      ld_steep = ld_dy > ld_dx;
      ld_major = ld_steep ? ld_dy : ld_dx;
      ld_minor = ld_steep ? ld_dx : ld_dy;
   end

   // Next walk state
   always_comb begin
      busy_in   = busy_ff;
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      stop_x_in = stop_x_ff;
      stop_y_in = stop_y_ff;
      neg_in    = neg_ff;
      steep_in  = steep_ff;
      err_in    = err_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      phase_in  = phase_ff;
      if (accept && (command == CMD_LOAD)) begin
         busy_in   = 1'b1;
         walk_x_in = ld_x1;
         walk_y_in = ld_y1;
         stop_x_in = ld_x2;
         stop_y_in = ld_y2;
         neg_in    = ld_neg;
         steep_in  = ld_steep;
         major_in  = ld_major;
         minor_in  = ld_minor;
         err_in    = ERR_W'({ld_minor, 1'b0}) - ERR_W'(ld_major);
         col_in    = '0;
         row_in    = '0;
         phase_in  = 1'b0;
      end else if (emit) begin
         if (!brush_done) begin
            // advance the scan: columns inner, rows outer
            if (col_ff >= span) begin
               col_in = '0;
               row_in = row_ff + BRUSH_W'(1);
            end else begin
               col_in = col_ff + BRUSH_W'(1);
            end
         end else begin
            col_in = '0;
            row_in = '0;
            if (phase_ff) begin
               // minor step after the extra brush
               if (steep_ff) begin
                  walk_x_in = x_moved;
               end else begin
                  walk_y_in = walk_y_ff + COORD_W'(1);
               end
               err_in   = err_down;
               phase_in = 1'b0;
            end else if (at_end) begin
               busy_in = 1'b0;
            end else begin
               // main-axis step; an extra brush comes first when error is positive
               if (steep_ff) begin
                  walk_y_in = walk_y_ff + COORD_W'(1);
               end else begin
                  walk_x_in = x_moved;
               end
               if (err_le_zero) begin
                  err_in   = err_up;
                  phase_in = 1'b0;
               end else begin
                  phase_in = 1'b1;
               end
            end
         end
      end
   end

   // Hold walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         walk_x_ff <= '0;
         walk_y_ff <= '0;
         stop_x_ff <= '0;
         stop_y_ff <= '0;
         neg_ff    <= 1'b0;
         steep_ff  <= 1'b0;
         err_ff    <= '0;
         major_ff  <= '0;
         minor_ff  <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         phase_ff  <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         stop_x_ff <= stop_x_in;
         stop_y_ff <= stop_y_in;
         neg_ff    <= neg_in;
         steep_ff  <= steep_in;
         err_ff    <= err_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         phase_ff  <= phase_in;
      end
   end

endmodule

/* tb/testbench.sv */
// Self-checking testbench: drives line and step items, predicts every brush pixel.
`timescale 1ns / 100ps

module testbench;
   import tlr_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 20;
   localparam int HOLD_CYCLES     = 300;
   localparam int NO_LIMIT        = 1 << 30;
   localparam int COORD_MAX       = (1 << COORD_W) - 1;
   localparam int ITEM_TARGET     = 1850;
   localparam int RANDOM_PHASES   = 8;
   localparam int MIN_PHASE_ITEMS = 40;
   localparam int REPORT_LIMIT    = 10;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct {
      coord_type            x;
      coord_type            y;
      logic [OFFSET_W-1:0]  offset;
      logic [COLOR_W-1:0]   color;
      logic                 last;
   } pixel_write_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_LOAD;
   coord_type             req_x_start = '0;
   coord_type             req_y_start = '0;
   coord_type             req_x_end = '0;
   coord_type             req_y_end = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   coord_type             rsp_pixel_x;
   coord_type             rsp_pixel_y;
   logic [OFFSET_W-1:0]   rsp_byte_offset;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  rsp_last_pixel;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Register mirror
   logic [RADIUS_W-1:0]   cfg_radius = RADIUS_RESET;
   logic [COLOR_W-1:0]    cfg_color  = COLOR_RESET;
   logic [STRIDE_W-1:0]   cfg_stride = STRIDE_RESET;
   logic [PBYTES_W-1:0]   cfg_pbytes = PBYTES_RESET;

   // Line walk state of the predictor
   bit        trace_busy = 1'b0;
   coord_type trace_x = '0, trace_y = '0, stop_x = '0, stop_y = '0;
   coord_type center_x = '0, center_y = '0;
   bit        x_dec = 1'b0, steep = 1'b0, extra_pending = 1'b0;
   int        err_acc = 0, major_len = 0, minor_len = 0;
   int        brush_col = 0, brush_row = 0;

   pixel_write_type pending_pixels[$];

   // Run control and statistics
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   int failures = 0;
   int items_sent = 0;
   int lines_loaded = 0;
   int pixels_checked = 0;
   int csr_writes = 0;
   int cycle_count = 0;
   int input_stall_cycles = 0;

   thick_line_rasterizer_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count cycles and input stalls; stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_valid && req_stall) input_stall_cycles <= input_stall_cycles + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels outstanding",
                  cycle_count, pending_pixels.size());
         $display("** thick_line_rasterizer_unit: FAILED **");
         $finish;
      end
   end

   function automatic void report_mismatch(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         report_mismatch($sformatf("pixel %0d %s: expected 0x%0h, got 0x%0h",
                                   pixels_checked, name, want, got));
   endfunction

   // ---------------------------------------------------------------- predictor

   function automatic bit trace_at_stop();
      return steep ? (trace_y == stop_y) : (trace_x == stop_x);
   endfunction

   // Order endpoints so y rises and set up the Bresenham terms
   function automatic void predict_load(coord_type xs, coord_type ys, coord_type xe,
                                        coord_type ye);
      coord_type x1, y1, x2, y2;
      int dx, dy;
      if (ys <= ye) begin
         x1 = xs; y1 = ys; x2 = xe; y2 = ye;
      end else begin
         x1 = xe; y1 = ye; x2 = xs; y2 = ys;
      end
      x_dec = x1 > x2;
      dx = x_dec ? int'(x1) - int'(x2) : int'(x2) - int'(x1);
      dy = int'(y2) - int'(y1);
      steep = dy > dx;
      major_len = steep ? dy : dx;
      minor_len = steep ? dx : dy;
      err_acc = 2 * minor_len - major_len;
      trace_x = x1;
      trace_y = y1;
      stop_x = x2;
      stop_y = y2;
      center_x = x1;
      center_y = y1;
      brush_col = 0;
      brush_row = 0;
      extra_pending = 1'b0;
      trace_busy = 1'b1;
   endfunction

   // Move to the next brush center, or end the line
   function automatic void advance_brush();
      if (extra_pending) begin
         if (steep) trace_x = x_dec ? trace_x - 1'b1 : trace_x + 1'b1;
         else trace_y = trace_y + 1'b1;
         err_acc += 2 * (minor_len - major_len);
         extra_pending = 1'b0;
         center_x = trace_x;
         center_y = trace_y;
      end else if (trace_at_stop()) begin
         trace_busy = 1'b0;
      end else begin
         if (steep) trace_y = trace_y + 1'b1;
         else trace_x = x_dec ? trace_x - 1'b1 : trace_x + 1'b1;
         if (err_acc <= 0) begin
            err_acc += 2 * minor_len;
            extra_pending = 1'b0;
         end else begin
            extra_pending = 1'b1;
         end
         center_x = trace_x;
         center_y = trace_y;
      end
   endfunction

   // Emit the current brush pixel and advance the brush counters
   function automatic void predict_step();
      pixel_write_type   pix;
      int                radius, span;
      logic [31:0]       sum_x, sum_y;
      longint unsigned   offset;
      bit                brush_done;
      radius = (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_radius);
      span = 2 * radius;
      sum_x = center_x + brush_col - radius;
      sum_y = center_y + brush_row - radius;
      pix.x = sum_x[COORD_W-1:0];
      pix.y = sum_y[COORD_W-1:0];
      offset = longint'(pix.y) * cfg_stride + longint'(pix.x) * cfg_pbytes;
      pix.offset = offset[OFFSET_W-1:0];
      pix.color = cfg_color;
      brush_done = brush_col >= span && brush_row >= span;
      pix.last = brush_done && !extra_pending && trace_at_stop();
      pending_pixels.push_back(pix);
      if (!brush_done) begin
         if (brush_col >= span) begin
            brush_col = 0;
            brush_row++;
         end else begin
            brush_col++;
         end
      end else begin
         brush_col = 0;
         brush_row = 0;
         advance_brush();
      end
   endfunction

   // ---------------------------------------------------------------- result side

   // Compare each accepted pixel with the oldest prediction
   initial begin : pixel_checker
      pixel_write_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel (%0d,%0d) offset 0x%0h",
                                         rsp_pixel_x, rsp_pixel_y, rsp_byte_offset));
            end else begin
               want = pending_pixels.pop_front();
               check_field("pixel_x", 32'(want.x), 32'(rsp_pixel_x));
               check_field("pixel_y", 32'(want.y), 32'(rsp_pixel_y));
               check_field("byte_offset", 32'(want.offset), 32'(rsp_byte_offset));
               check_field("pixel_color", 32'(want.color), 32'(rsp_pixel_color));
               check_field("last_pixel", 32'(want.last), 32'(rsp_last_pixel));
               pixels_checked++;
            end
         end
      end
   end

   // Stall the result side in random bursts, or for one long hold-off on request
   initial begin : result_stall_driver
      int burst_left;
      int hold_left;
      bit stall_next;
      burst_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            stall_next = 1'b1;
         end else if (!idle_on) begin
            burst_left = 0;
            stall_next = 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            stall_next = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(0, 18);
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // ---------------------------------------------------------------- drivers

   // Offer one item, hold it until accepted, then predict its effect
   task automatic send_item(cmd_type cmd, coord_type xs, coord_type ys, coord_type xe,
                            coord_type ye);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end <= xe;
      req_y_end <= ye;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_LOAD) begin
         predict_load(xs, ys, xe, ye);
      end else if (trace_busy) begin
         predict_step();
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_step();
      send_item(CMD_STEP, coord_type'($urandom_range(0, COORD_MAX)),
                coord_type'($urandom_range(0, COORD_MAX)),
                coord_type'($urandom_range(0, COORD_MAX)),
                coord_type'($urandom_range(0, COORD_MAX)));
   endtask

   // Load a line and step it until it ends or the step budget runs out
   task automatic draw_line(int xs, int ys, int xe, int ye, int max_steps);
      int steps;
      send_item(CMD_LOAD, coord_type'(xs), coord_type'(ys), coord_type'(xe), coord_type'(ye));
      lines_loaded++;
      steps = 0;
      while (trace_busy && steps < max_steps) begin
         send_step();
         steps++;
      end
   endtask

   // Drop valid, wait for every predicted pixel, then let the pipeline settle
   task automatic wait_block_idle(int settle);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // One register access: setup then access phase; psel is left high
   task automatic csr_access(bit write_op, reg_index_type idx, logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel <= 1'b1;
      pwrite <= write_op;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      penable <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] register_mirror(reg_index_type idx);
      logic [CSR_DATA_W-1:0] value;
      value = '0;
      case (idx)
         REG_BRUSH_RADIUS: value = CSR_DATA_W'(cfg_radius);
         REG_PEN_COLOR:    value = CSR_DATA_W'(cfg_color);
         REG_ROW_STRIDE:   value = CSR_DATA_W'(cfg_stride);
         REG_PIXEL_BYTES:  value = CSR_DATA_W'(cfg_pbytes);
         default:          value = '0;
      endcase
      return value;
   endfunction

   // Read a register back and compare with the mirror; ends the transfer
   task automatic check_register(reg_index_type idx);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, idx, '0, rdata);
      psel <= 1'b0;
      if (rdata !== register_mirror(idx))
         report_mismatch($sformatf("register %s read 0x%0h, expected 0x%0h",
                                   idx.name(), rdata, register_mirror(idx)));
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, idx, value, unused);
      case (idx)
         REG_BRUSH_RADIUS: cfg_radius = value[RADIUS_W-1:0];
         REG_PEN_COLOR:    cfg_color = value[COLOR_W-1:0];
         REG_ROW_STRIDE:   cfg_stride = value[STRIDE_W-1:0];
         REG_PIXEL_BYTES:  cfg_pbytes = value[PBYTES_W-1:0];
         default:          cfg_radius = cfg_radius;
      endcase
      csr_writes++;
      check_register(idx);
   endtask

   function automatic int near_coord(int base, int reach);
      int delta, target;
      delta = $urandom_range(0, 2 * reach) - reach;
      target = base + delta;
      if (target < 0 || target > COORD_MAX) target = base - delta;
      return target;
   endfunction

   // ---------------------------------------------------------------- tests

   // Check reset values, an idle step, and short lines with default settings
   task automatic test_reset_values();
      check_register(REG_BRUSH_RADIUS);
      check_register(REG_PEN_COLOR);
      check_register(REG_ROW_STRIDE);
      check_register(REG_PIXEL_BYTES);
      send_step();
      draw_line(10, 20, 10, 20, NO_LIMIT);
      draw_line(0, 0, 3, 1, NO_LIMIT);
      wait_block_idle(SETTLE_CYCLES);
   endtask

   // Walk every line shape, points at the frame corners, and an abandoned line
   task automatic test_line_shapes();
      write_register(REG_BRUSH_RADIUS, 0);
      draw_line(5, 5, 12, 5, NO_LIMIT);
      draw_line(7, 3, 7, 11, NO_LIMIT);
      draw_line(10, 10, 20, 14, NO_LIMIT);
      draw_line(30, 10, 18, 15, NO_LIMIT);
      draw_line(50, 50, 53, 60, NO_LIMIT);
      draw_line(60, 40, 57, 49, NO_LIMIT);
      draw_line(80, 80, 86, 86, NO_LIMIT);
      draw_line(90, 95, 99, 90, NO_LIMIT);
      wait_block_idle(SETTLE_CYCLES);
      write_register(REG_BRUSH_RADIUS, 1);
      draw_line(0, 0, 0, 0, NO_LIMIT);
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, NO_LIMIT);
      draw_line(COORD_MAX - 2, 0, COORD_MAX, 3, NO_LIMIT);
      // reload while the previous line is still running
      draw_line(100, 100, 140, 120, 4);
      draw_line(200, 210, 203, 211, NO_LIMIT);
      send_step();
      wait_block_idle(SETTLE_CYCLES);
   endtask

   // Drive register extremes: zero products, wrapped offsets, the widest brush
   task automatic test_register_extremes();
      write_register(REG_BRUSH_RADIUS, 0);
      write_register(REG_PEN_COLOR, 0);
      write_register(REG_ROW_STRIDE, 0);
      write_register(REG_PIXEL_BYTES, 0);
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 5, COORD_MAX - 2, NO_LIMIT);
      wait_block_idle(SETTLE_CYCLES);
      write_register(REG_PEN_COLOR, 24'hFFFFFF);
      write_register(REG_ROW_STRIDE, 15'h7FFF);
      write_register(REG_PIXEL_BYTES, 3'd7);
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, NO_LIMIT);
      draw_line(0, 0, 2, 1, NO_LIMIT);
      wait_block_idle(SETTLE_CYCLES);
      write_register(REG_BRUSH_RADIUS, MAX_RADIUS);
      draw_line(5, COORD_MAX - 5, 5, COORD_MAX - 5, NO_LIMIT);
      wait_block_idle(SETTLE_CYCLES);
   endtask

   // Change registers partway through a line while the pipeline is empty
   task automatic test_mid_line_update();
      write_register(REG_BRUSH_RADIUS, 3);
      write_register(REG_PEN_COLOR, 24'h123456);
      write_register(REG_ROW_STRIDE, 640);
      write_register(REG_PIXEL_BYTES, 4);
      draw_line(300, 300, 305, 302, 5);
      wait_block_idle(SETTLE_CYCLES);
      // column counter now beyond the smaller span
      write_register(REG_BRUSH_RADIUS, 1);
      repeat (4) send_step();
      wait_block_idle(SETTLE_CYCLES);
      write_register(REG_BRUSH_RADIUS, 0);
      repeat (2) send_step();
      wait_block_idle(SETTLE_CYCLES);
      write_register(REG_PEN_COLOR, 24'hA5C3E1);
      write_register(REG_ROW_STRIDE, 1023);
      write_register(REG_BRUSH_RADIUS, 2);
      while (trace_busy) send_step();
      wait_block_idle(SETTLE_CYCLES);
   endtask

   // Hold the result side off while items keep coming, so the input stalls
   task automatic test_output_holdoff();
      write_register(REG_BRUSH_RADIUS, 1);
      hold_request = 1'b1;
      draw_line(400, 500, 410, 505, NO_LIMIT);
      wait_block_idle(SETTLE_CYCLES);
   endtask

   // Mostly complete short lines, with long, abandoned and idle-step noise mixed in
   task automatic random_line(int radius);
      int kind, reach, budget, xs, ys;
      kind = $urandom_range(0, 9);
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      if (kind == 9) begin
         draw_line(xs, ys, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, 40));
      end else begin
         if (kind < 7) reach = (radius == 0) ? 12 : 6 - radius;
         else reach = (radius == 0) ? 60 : 4;
         budget = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : NO_LIMIT;
         draw_line(xs, ys, near_coord(xs, reach), near_coord(ys, reach), budget);
      end
      if ($urandom_range(0, 5) == 0) send_step();
   endtask

   // Share what is left of the item budget over the random phases
   task automatic test_random_lines();
      int phase, first, radius, phase_items;
      phase_items = (ITEM_TARGET - items_sent) / RANDOM_PHASES;
      if (phase_items < MIN_PHASE_ITEMS) phase_items = MIN_PHASE_ITEMS;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0:       radius = 0;
            1:       radius = 1;
            2:       radius = 2;
            default: radius = $urandom_range(0, 3);
         endcase
         // last phase runs with no idling on either side
         idle_on = (phase != RANDOM_PHASES - 1);
         write_register(REG_BRUSH_RADIUS, radius);
         if (phase == 2) begin
            write_register(REG_PEN_COLOR, 24'hFFFFFF);
            write_register(REG_ROW_STRIDE, 15'h7FFF);
            write_register(REG_PIXEL_BYTES, 3'd7);
         end else if (phase == 5) begin
            write_register(REG_PEN_COLOR, 0);
            write_register(REG_ROW_STRIDE, 0);
            write_register(REG_PIXEL_BYTES, 0);
         end else begin
            write_register(REG_PEN_COLOR, $urandom_range(0, 24'hFFFFFF));
            write_register(REG_ROW_STRIDE, $urandom_range(1, 16384));
            write_register(REG_PIXEL_BYTES, $urandom_range(1, 4));
         end
         first = items_sent;
         while (items_sent - first < phase_items) random_line(radius);
         wait_block_idle(SETTLE_CYCLES);
      end
   endtask

   initial begin : run_tests
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_line_shapes();
      test_register_extremes();
      test_mid_line_update();
      test_output_holdoff();
      test_random_lines();
      wait_block_idle(END_CYCLES);
      $display("Run covered %0d items over %0d lines and %0d register writes; %0d pixels checked.",
               items_sent, lines_loaded, csr_writes, pixels_checked);
      $display("Result hold-off stalled the input for %0d cycles; %0d mismatches in total.",
               input_stall_cycles, failures);
      if (failures == 0) begin
         $display("** thick_line_rasterizer_unit: PASSED **");
      end else begin
         $display("** thick_line_rasterizer_unit: FAILED **");
      end
      $finish;
   end

endmodule
